[rtl/assert_macros.svh]
// assertion macros shared by the rtl modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// property must hold at every clock edge outside reset
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// condition must never be seen at a clock edge outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, prop, msg)
`endif

`endif

[rtl/spq_pkg.sv]
// types and constants of the sorted priority queue
package spq_pkg;

	localparam int CAPACITY = 16;
	localparam int VAL_W    = 32;
	localparam int OCC_W    = 5;
	localparam int CNT_W    = $clog2(CAPACITY + 1);

	localparam logic MODE_ENQ = 1'b0;
	localparam logic MODE_DEQ = 1'b1;

	typedef struct packed {
		logic                    mode;
		logic signed [VAL_W-1:0] value;
	} in_item_t;

	typedef struct packed {
		logic signed [VAL_W-1:0] removed_value;
		logic                    removed_valid;
		logic                    underflow;
		logic                    overflow;
		logic [OCC_W-1:0]        occupancy;
	} out_item_t;

	// controller to datapath
	typedef struct packed {
		logic finish;
		logic insert;
		logic remove;
		logic set_over;
		logic set_under;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic dequeue;
		logic full;
		logic empty;
	} dp_stat_t;

endpackage

[rtl/spq_datapath.sv]
// sorted cell array, entry count and result register
`include "assert_macros.svh"
module spq_datapath import spq_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      load,
	input  in_item_t  item,
	input  dp_cmd_t   cmd,
	output dp_stat_t  stat,
	output out_item_t result
);

	in_item_t                item_q;
	logic signed [VAL_W-1:0] cells_q [CAPACITY];
	logic signed [VAL_W-1:0] cell_nxt [CAPACITY];
	logic                    keep [CAPACITY];
	logic [CNT_W-1:0]        count_q;
	logic [CNT_W-1:0]        count_nxt;
	out_item_t               result_q;

	always_ff @(posedge clk) begin
		if (load) begin
			item_q <= item;
		end
	end

	assign stat.dequeue = (item_q.mode == MODE_DEQ);
	assign stat.full    = (count_q == CNT_W'(CAPACITY));
	assign stat.empty   = (count_q == '0);

	// each cell keeps its value when it holds an entry not smaller than the new one
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		assign keep[i] = (CNT_W'(i) < count_q) && (cells_q[i] >= item_q.value);

		always_comb begin
			if (cmd.remove) begin
				cell_nxt[i] = (i == CAPACITY - 1) ? cells_q[i] : cells_q[(i + 1) % CAPACITY];
			end else if (keep[i]) begin
				cell_nxt[i] = cells_q[i];
			end else if (i == 0) begin
				cell_nxt[i] = item_q.value;
			end else if (keep[(i + CAPACITY - 1) % CAPACITY]) begin
				cell_nxt[i] = item_q.value;
			end else begin
				cell_nxt[i] = cells_q[(i + CAPACITY - 1) % CAPACITY];
			end
		end

		always_ff @(posedge clk) begin
			if (cmd.insert || cmd.remove) begin
				cells_q[i] <= cell_nxt[i];
			end
		end
	end

	always_comb begin
		count_nxt = count_q;
		if (cmd.insert) begin
			count_nxt = count_q + CNT_W'(1);
		end else if (cmd.remove) begin
			count_nxt = count_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			count_q <= count_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			result_q.removed_value <= cmd.remove ? cells_q[0] : '0;
			result_q.removed_valid <= cmd.remove;
			result_q.underflow     <= cmd.set_under;
			result_q.overflow      <= cmd.set_over;
			result_q.occupancy     <= OCC_W'(count_nxt);
		end
	end

	assign result = result_q;

	`ASSERT_CLK(a_count_range, clk, arst_n, count_q <= CNT_W'(CAPACITY), "entry count above capacity")
	`ASSERT_NEVER(a_insert_full, clk, arst_n, cmd.insert && stat.full, "insert into full queue")
	`ASSERT_CLK(a_remove_count, clk, arst_n, cmd.remove |=> count_q == $past(count_q) - CNT_W'(1), "remove did not drop the count")

endmodule

[rtl/spq_ctrl.sv]
// controller state machine of the sorted priority queue
`include "assert_macros.svh"
module spq_ctrl import spq_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  dp_stat_t stat,
	output logic     busy,
	output logic     load,
	output dp_cmd_t  cmd,
	output logic     done
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_EXEC = 1'b1;

	logic state_q;
	logic done_q;

	assign busy = (state_q == ST_EXEC);
	assign load = start && !busy;

	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_EXEC: begin
				cmd.finish = 1'b1;
				if (stat.dequeue) begin
					cmd.remove    = !stat.empty;
					cmd.set_under = stat.empty;
				end else begin
					cmd.insert   = !stat.full;
					cmd.set_over = stat.full;
				end
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= load ? ST_EXEC : ST_IDLE;
			done_q  <= (state_q == ST_EXEC);
		end
	end

	assign done = done_q;

	`ASSERT_CLK(a_one_action, clk, arst_n, $onehot0({cmd.insert, cmd.remove, cmd.set_over, cmd.set_under}), "more than one action at once")
	`ASSERT_CLK(a_done_after_exec, clk, arst_n, done |-> $past(state_q == ST_EXEC), "done without an execute cycle")
	`ASSERT_CLK(a_accept_busy, clk, arst_n, load |=> busy, "accepted item did not start work")

endmodule

[rtl/sorted_priority_queue.sv]
// sorted priority queue, largest first: top level
// flow: an item taken while idle is latched and applied in the execute step; its result is on result
// with done, both registered at the end of the execute step; no new item is taken while busy in the
// execute step of the controller; the receiver cannot stall
// reset: arst_n clears the entry count and the controller; entries are not cleared
// and hold don't-care values until written
module sorted_priority_queue import spq_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  in_item_t  item,
	output logic      busy,
	output logic      done,
	output out_item_t result
);

	// command and status between the controller and the datapath
	dp_cmd_t  cmd;
	dp_stat_t stat;
	logic     load;

	// controller: idle / execute, decides insert, remove or flag
	spq_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.busy   (busy),
		.load   (load),
		.cmd    (cmd),
		.done   (done)
	);

	// datapath: item latch, sorted cell array with parallel compare, result register
	spq_datapath u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (load),
		.item   (item),
		.cmd    (cmd),
		.stat   (stat),
		.result (result)
	);

endmodule

[tb/sv/tb_top.sv]
// testbench for the sorted priority queue: directed and random items checked against a predictor
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import spq_pkg::*;

	logic      clk;
	logic      arst_n;
	logic      start;
	logic      busy;
	logic      done;
	in_item_t  item;
	out_item_t result;

	// predicted queue contents, head at index 0, largest value first
	logic signed [VAL_W-1:0] held[CAPACITY];
	int unsigned             held_count;

	// results still owed by the block, oldest first
	out_item_t pending_results[$];

	int error_count;
	int items_sent;
	int removals_seen;
	int underflows_seen;
	int overflows_seen;
	int full_hits;
	int idle_pct;
	bit filling;

	sorted_priority_queue dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.item   (item),
		.busy   (busy),
		.done   (done),
		.result (result)
	);

	always #6 clk = ~clk;

	// apply one item to the predicted queue and return the result it should give
	function automatic out_item_t predict_queue_op(in_item_t op);
		out_item_t r;
		int unsigned pos;
		r = '0;
		if (op.mode == MODE_ENQ) begin
			if (held_count >= CAPACITY) begin
				// full: value dropped, queue unchanged
				r.overflow = 1'b1;
				overflows_seen++;
			end else begin
				// stop at the first strictly smaller entry so equal values keep arrival order
				pos = 0;
				while (pos < held_count && held[pos] >= op.value)
					pos++;
				for (int i = held_count; i > pos; i--)
					held[i] = held[i-1];
				held[pos] = op.value;
				held_count++;
				if (held_count == CAPACITY)
					full_hits++;
			end
		end else begin
			if (held_count == 0) begin
				// empty: nothing to take
				r.underflow = 1'b1;
				underflows_seen++;
			end else begin
				r.removed_value = held[0];
				r.removed_valid = 1'b1;
				for (int i = 1; i < held_count; i++)
					held[i-1] = held[i];
				held_count--;
				removals_seen++;
			end
		end
		r.occupancy = OCC_W'(held_count);
		return r;
	endfunction

	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$display("%0t ns: %s mismatch, expected %0d (0x%08h), actual %0d (0x%08h)",
				$time, name, $signed(want), want, $signed(got), got);
			error_count++;
		end
	endfunction

	// compare every strobed result with the oldest prediction
	always @(posedge clk) begin : check_results
		out_item_t want;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				$display("%0t ns: result with no item outstanding, actual 0x%h", $time, result);
				error_count++;
			end else begin
				want = pending_results.pop_front();
				check_field("removed_value", want.removed_value, result.removed_value);
				check_field("removed_valid", want.removed_valid, result.removed_valid);
				check_field("underflow", want.underflow, result.underflow);
				check_field("overflow", want.overflow, result.overflow);
				check_field("occupancy", want.occupancy, result.occupancy);
			end
		end
	end

	// called at a falling edge; returns at the falling edge after the item is taken,
	// with start still high so a following item goes out without a gap
	task automatic send_item(input logic m, input logic signed [VAL_W-1:0] v);
		in_item_t op;
		op.mode  = m;
		op.value = v;
		if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(4, 1)) @(negedge clk);
		end
		start <= 1'b1;
		item  <= op;
		do
			@(posedge clk);
		while (busy);
		pending_results.push_back(predict_queue_op(op));
		items_sent++;
		@(negedge clk);
	endtask

	// hold off the sender until every result owed has come back
	task automatic wait_for_results();
		start <= 1'b0;
		@(negedge clk);
		while (pending_results.size() != 0)
			@(negedge clk);
	endtask

	// mostly full-range values, with a share of near-zero values for ties and the extremes
	function automatic logic signed [VAL_W-1:0] pick_value();
		case ($urandom_range(9))
			0, 1:    return VAL_W'(int'($urandom_range(6)) - 3);
			2:       return $urandom_range(1) ? 32'sh7fff_ffff : 32'sh8000_0000;
			default: return $urandom;
		endcase
	endfunction

	// dequeue from the empty queue, value bits must not matter
	task automatic test_empty_dequeue();
		send_item(MODE_DEQ, 32'sd0);
		send_item(MODE_DEQ, -32'sd1);
	endtask

	// largest, smallest, zero and its neighbors must come out in descending order
	task automatic test_value_extremes();
		send_item(MODE_ENQ, 32'sh8000_0000);
		send_item(MODE_ENQ, 32'sd0);
		send_item(MODE_ENQ, 32'sh7fff_ffff);
		send_item(MODE_ENQ, -32'sd1);
		send_item(MODE_ENQ, 32'sd1);
		repeat (5)
			send_item(MODE_DEQ, $urandom);
	endtask

	// equal values mixed with a smaller one, then one dequeue past empty
	task automatic test_equal_values();
		send_item(MODE_ENQ, 32'sd7);
		send_item(MODE_ENQ, 32'sd7);
		send_item(MODE_ENQ, -32'sd3);
		send_item(MODE_ENQ, 32'sd7);
		repeat (5)
			send_item(MODE_DEQ, 32'sd7);
	endtask

	// fill to capacity, push twice more to hit overflow, then drain into underflow
	task automatic test_fill_past_capacity();
		repeat (CAPACITY + 2)
			send_item(MODE_ENQ, pick_value());
		repeat (CAPACITY + 1)
			send_item(MODE_DEQ, $urandom);
	endtask

	// random walk between empty and full so both ends are reached again and again
	task automatic test_random_traffic(input int count, input int pct);
		logic m;
		idle_pct = pct;
		for (int n = 0; n < count; n++) begin
			if (held_count == CAPACITY)
				filling = 1'b0;
			else if (held_count == 0)
				filling = 1'b1;
			else if ($urandom_range(99) < 3)
				filling = ~filling;
			m = ($urandom_range(99) < (filling ? 75 : 25)) ? MODE_ENQ : MODE_DEQ;
			send_item(m, pick_value());
		end
		// let the queue catch up before the next phase
		wait_for_results();
	endtask

	initial begin
		clk        = 1'b0;
		arst_n     = 1'b0;
		start      = 1'b0;
		item       = '0;
		held_count = 0;
		idle_pct   = 0;
		filling    = 1'b1;
		error_count     = 0;
		items_sent      = 0;
		removals_seen   = 0;
		underflows_seen = 0;
		overflows_seen  = 0;
		full_hits       = 0;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		idle_pct = 17;
		test_empty_dequeue();
		test_value_extremes();
		test_equal_values();
		test_fill_past_capacity();

		// sender idles seldom, then often, then never
		test_random_traffic(360, 17);
		test_random_traffic(360, 77);
		test_random_traffic(380, 0);

		wait_for_results();
		repeat (6) @(negedge clk);
		$display("run covered %0d items: %0d removals, %0d underflows, %0d overflows",
			items_sent, removals_seen, underflows_seen, overflows_seen);
		$display("queue reached full occupancy %0d times, %0d mismatches", full_hits, error_count);
		if (error_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	// watchdog well beyond the slowest correct run
	initial begin
		#5_000_000;
		$display("timeout with %0d results outstanding", pending_results.size());
		$display("RESULT: ERROR");
		$finish;
	end

endmodule

[files.f]
+incdir+rtl
rtl/spq_pkg.sv
rtl/spq_datapath.sv
rtl/spq_ctrl.sv
rtl/sorted_priority_queue.sv
tb/sv/tb_top.sv
